// ===== rtl/ts_packet_header_filter_assert.svh =====
// Assertion helpers used by the filter's sequencer module.
// Each macro expects clk and arst_n in scope.
`ifndef TS_PACKET_HEADER_FILTER_ASSERT_SVH
`define TS_PACKET_HEADER_FILTER_ASSERT_SVH

// Same-cycle implication.
`define TSPHF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsphf assertion failed");

// Next-cycle implication.
`define TSPHF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsphf assertion failed");

`endif

// ===== rtl/tsphf_pkg.sv =====
package tsphf_pkg;

	localparam int MAX_STREAMS = 16;
	localparam int SLOT_W      = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

	localparam logic [8:0] PKT_LEN = 9'd188;

	typedef enum logic [2:0] {
		ROUTE_NONE     = 3'd0,
		ROUTE_DESCR    = 3'd1,
		ROUTE_SECTION  = 3'd2,
		ROUTE_SEC_HOLD = 3'd3,
		ROUTE_TELETEXT = 3'd4,
		ROUTE_RAW      = 3'd5,
		ROUTE_RAW_DROP = 3'd6,
		ROUTE_LOADED   = 3'd7
	} route_t;

	localparam logic [1:0] TYPE_SECTION  = 2'd0;
	localparam logic [1:0] TYPE_TELETEXT = 2'd1;

	// One stream table row as stored in the RAM.
	typedef struct packed {
		logic [12:0] pid;
		logic [1:0]  stype;
		logic        enable;
		logic [3:0]  cc_exp;
		logic        cc_known;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Table load request.
	typedef struct packed {
		logic [3:0]  index;
		logic [12:0] pid;
		logic [1:0]  stype;
		logic        enable;
	} load_t;

	// Decoded packet header.
	typedef struct packed {
		logic [12:0] pid;
		logic        pusi;
		logic [8:0]  offset;
		logic        scrambled;
		logic        has_payload;
		logic [3:0]  cc;
		logic        pcr_ok;
		logic [32:0] pcr_base;
	} hdr_t;

	typedef struct packed {
		logic        matched;
		logic [3:0]  stream_slot;
		route_t      route;
		logic        cc_error;
		logic        payload_start;
		logic [8:0]  payload_offset;
		logic        pcr_valid;
		logic [32:0] pcr_base;
	} result_t;

endpackage

// ===== rtl/tsphf_ram.sv =====
module tsphf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/tsphf_decode.sv =====
module tsphf_decode (
	input  logic           full_mode,
	input  logic [7:0]     hdr_byte1,
	input  logic [7:0]     hdr_byte2,
	input  logic [7:0]     hdr_byte3,
	input  logic [7:0]     adapt_length,
	input  logic [7:0]     adapt_flags,
	input  logic [39:0]    pcr_raw,
	output tsphf_pkg::hdr_t hdr
);
	import tsphf_pkg::*;

	logic adapt;

	always_comb begin
		adapt           = hdr_byte3[5];
		hdr.pid         = {hdr_byte1[4:0], hdr_byte2};
		hdr.pusi        = hdr_byte1[6];
		hdr.offset      = adapt ? (9'(adapt_length) + 9'd5) : 9'd4;
		hdr.scrambled   = full_mode && (hdr_byte3[7:6] != 2'b00);
		hdr.has_payload = hdr_byte3[4];
		hdr.cc          = hdr_byte3[3:0];
		hdr.pcr_ok      = full_mode && adapt && (adapt_length != 8'd0) && adapt_flags[4];
		// base is the top 33 bits of the five-byte PCR field
		hdr.pcr_base    = hdr.pcr_ok ? pcr_raw[39:7] : 33'd0;
	end

endmodule

// ===== rtl/tsphf_seq.sv =====
`include "ts_packet_header_filter_assert.svh"

module tsphf_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               start_load,
	input  tsphf_pkg::load_t   load,
	input  tsphf_pkg::hdr_t    hdr,
	input  logic               out_free,
	output logic               idle,
	output logic               push,
	output tsphf_pkg::result_t res
);
	import tsphf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_SCAN = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_STREAMS - 1);

	state_t              state_q;
	logic [MAX_STREAMS-1:0] valid_q;
	logic [SLOT_W-1:0]   rd_idx_q;
	logic                rd_more_q;
	logic                chk_v_s1;
	logic [SLOT_W-1:0]   chk_idx_s1;
	result_t             res_q;

	logic                rd_en;
	logic [ENTRY_W-1:0]  rd_data;
	logic                wr_en;
	logic [SLOT_W-1:0]   wr_addr;
	entry_t              wr_entry;
	entry_t              ent;
	logic                hit;
	logic                last;
	logic                cc_upd;
	logic                err;
	logic                load_ok;
	route_t              route;
	result_t             scan_res;
	result_t             load_res;

	tsphf_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_STREAMS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (rd_en),
		.rd_addr(rd_idx_q),
		.rd_data(rd_data)
	);

	always_comb begin
		rd_en   = (state_q == S_SCAN) && rd_more_q;
		// never-loaded rows read as disabled with an unknown counter
		ent     = valid_q[chk_idx_s1] ? entry_t'(rd_data) : '0;
		hit     = (state_q == S_SCAN) && chk_v_s1 && ent.enable && (ent.pid == hdr.pid);
		last    = (state_q == S_SCAN) && chk_v_s1 && (chk_idx_s1 == LAST_SLOT);
		cc_upd  = !hdr.scrambled && hdr.has_payload;
		err     = cc_upd && ent.cc_known && (hdr.cc != ent.cc_exp);
		load_ok = int'(load.index) < MAX_STREAMS;

		case (ent.stype)
			TYPE_SECTION:  route = (err || hdr.offset >= PKT_LEN) ? ROUTE_SEC_HOLD : ROUTE_SECTION;
			TYPE_TELETEXT: route = ROUTE_TELETEXT;
			default:       route = (hdr.offset > PKT_LEN) ? ROUTE_RAW_DROP : ROUTE_RAW;
		endcase
		if (hdr.scrambled) begin
			route = ROUTE_DESCR;
		end

		scan_res                = '0;
		scan_res.payload_start  = hdr.pusi;
		scan_res.payload_offset = hdr.offset;
		scan_res.route          = ROUTE_NONE;
		if (hit) begin
			scan_res.matched     = 1'b1;
			scan_res.stream_slot = 4'(chk_idx_s1);
			scan_res.route       = route;
			scan_res.cc_error    = err;
			scan_res.pcr_valid   = hdr.pcr_ok;
			scan_res.pcr_base    = hdr.pcr_base;
		end

		load_res                = '0;
		load_res.stream_slot    = load.index;
		load_res.route          = ROUTE_LOADED;
		load_res.payload_offset = 9'd4;

		wr_en    = 1'b0;
		wr_addr  = chk_idx_s1;
		wr_entry = ent;
		if (state_q == S_LOAD) begin
			wr_en             = load_ok;
			wr_addr           = SLOT_W'(load.index);
			wr_entry.pid      = load.pid;
			wr_entry.stype    = load.stype;
			wr_entry.enable   = load.enable;
			wr_entry.cc_exp   = 4'd0;
			wr_entry.cc_known = 1'b0;
		end else if (hit && cc_upd) begin
			// write back the counter of the matched row
			wr_en             = 1'b1;
			wr_entry.cc_known = 1'b1;
			wr_entry.cc_exp   = hdr.cc + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			rd_idx_q  <= '0;
			rd_more_q <= 1'b0;
			chk_v_s1  <= 1'b0;
		end else begin
			chk_v_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q   <= start_load ? S_LOAD : S_SCAN;
						rd_idx_q  <= '0;
						rd_more_q <= !start_load;
					end
				end
				S_LOAD: begin
					if (load_ok) begin
						valid_q[SLOT_W'(load.index)] <= 1'b1;
					end
					state_q <= S_HOLD;
				end
				S_SCAN: begin
					// stop reading on a hit or after the last row has been checked
					if (hit || last) begin
						state_q   <= S_HOLD;
						rd_more_q <= 1'b0;
					end else if (rd_en) begin
						if (rd_idx_q == LAST_SLOT) begin
							rd_more_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		if (state_q == S_LOAD) begin
			res_q <= load_res;
		end else if (hit || last) begin
			res_q <= scan_res;
		end
	end

	assign idle = (state_q == S_IDLE);
	assign push = (state_q == S_HOLD) && out_free;
	assign res  = res_q;

	`TSPHF_ASSERT_IMP(a_start_idle, start, state_q == S_IDLE)
	`TSPHF_ASSERT_IMP(a_no_rw_clash, rd_en && wr_en, rd_idx_q != wr_addr)
	`TSPHF_ASSERT_IMP(a_wr_source, wr_en, (state_q == S_LOAD) || (state_q == S_SCAN && chk_v_s1))
	`TSPHF_ASSERT_IMP(a_scan_alive, state_q == S_SCAN, rd_more_q || chk_v_s1)

endmodule

// ===== rtl/ts_packet_header_filter.sv =====
// Transport stream header filter: each input beat either loads one row of a
// MAX_STREAMS-row stream table (s_tuser low) or presents one packet header
// (s_tuser high); every beat yields exactly one result beat. The table sits in
// a single-port-read RAM that is walked one row per cycle, lowest row first,
// and the first enabled row with the packet PID wins; its continuity counter
// is checked and written back in the same cycle. A load result passes from
// the load state to the hold state; a header result is registered when the
// scan hits or checks the last row, then waits in the hold state. From there
// it moves into the output register, and the next beat is accepted as soon
// as it does, so a stalled master side costs at most one waiting result.
// full_mode resets to 1 and is written through the cfg port, which is always
// ready; write it only while the block is idle.
module ts_packet_header_filter (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_tvalid,
	output logic         s_tready,
	// entry_index[3:0], entry_pid[16:4], entry_type[18:17], entry_enable[19],
	// hdr_byte1[27:20], hdr_byte2[35:28], hdr_byte3[43:36],
	// adapt_length[51:44], adapt_flags[59:52], pcr_raw[99:60], zero fill
	input  logic [103:0] s_tdata,
	// kind[0]: 0 table load, 1 packet header
	input  logic         s_tuser,

	output logic         m_tvalid,
	input  logic         m_tready,
	// matched[0], stream_slot[4:1], cc_error[5], payload_start[6],
	// payload_offset[15:7], pcr_valid[16], pcr_base[49:17], zero fill
	output logic [55:0]  m_tdata,
	// route[2:0]
	output logic [2:0]   m_tuser,

	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data
);
	import tsphf_pkg::*;

	logic         full_mode_q;

	// captured beat
	load_t        load_q;
	logic [7:0]   hdr_byte1_q;
	logic [7:0]   hdr_byte2_q;
	logic [7:0]   hdr_byte3_q;
	logic [7:0]   adapt_length_q;
	logic [7:0]   adapt_flags_q;
	logic [39:0]  pcr_raw_q;

	logic         m_tvalid_q;
	result_t      out_q;

	hdr_t         hdr;
	result_t      res;
	logic         start;
	logic         idle;
	logic         push;
	logic         out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = idle;
	assign start     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			full_mode_q <= cfg_data;
		end
	end

	// Hold the accepted beat for the whole lookup.
	always_ff @(posedge clk) begin
		if (start) begin
			load_q.index   <= s_tdata[3:0];
			load_q.pid     <= s_tdata[16:4];
			load_q.stype   <= s_tdata[18:17];
			load_q.enable  <= s_tdata[19];
			hdr_byte1_q    <= s_tdata[27:20];
			hdr_byte2_q    <= s_tdata[35:28];
			hdr_byte3_q    <= s_tdata[43:36];
			adapt_length_q <= s_tdata[51:44];
			adapt_flags_q  <= s_tdata[59:52];
			pcr_raw_q      <= s_tdata[99:60];
		end
	end

	tsphf_decode u_decode (
		.full_mode   (full_mode_q),
		.hdr_byte1   (hdr_byte1_q),
		.hdr_byte2   (hdr_byte2_q),
		.hdr_byte3   (hdr_byte3_q),
		.adapt_length(adapt_length_q),
		.adapt_flags (adapt_flags_q),
		.pcr_raw     (pcr_raw_q),
		.hdr         (hdr)
	);

	tsphf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_load(!s_tuser),
		.load      (load_q),
		.hdr       (hdr),
		.out_free  (out_free),
		.idle      (idle),
		.push      (push),
		.res       (res)
	);

	// Output register: advance on push, drop valid once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.route;
	assign m_tdata  = {6'd0, out_q.pcr_base, out_q.pcr_valid, out_q.payload_offset,
		out_q.payload_start, out_q.cc_error, out_q.stream_slot, out_q.matched};

endmodule
